[rtl/uhid_pkg.sv]
// Shared types, request codes and descriptor tables for the HID control endpoint responder.
`default_nettype none

package uhid_pkg;

  localparam int unsigned BEAT_BYTES       = 8;
  localparam int unsigned MAX_REPORT_BYTES = 64;
  localparam int unsigned BEAT_W           = 8 * BEAT_BYTES;
  localparam int unsigned TAKE_W           = 4;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned DESC_DEPTH       = 244;
  localparam int unsigned STR_DEPTH        = 102;

  // Request type groups from bits 6:5 of bmRequestType.
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;

  // Standard request codes.
  localparam logic [7:0] STD_GET_STATUS     = 8'h00;
  localparam logic [7:0] STD_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] STD_SET_CONFIG     = 8'h09;
  localparam logic [7:0] STD_SET_INTERFACE  = 8'h0B;

  // HID class request codes.
  localparam logic [7:0] HID_GET_REPORT   = 8'h01;
  localparam logic [7:0] HID_GET_PROTOCOL = 8'h03;
  localparam logic [7:0] HID_SET_REPORT   = 8'h09;
  localparam logic [7:0] HID_SET_IDLE     = 8'h0A;
  localparam logic [7:0] HID_SET_PROTOCOL = 8'h0B;

  // Descriptor types.
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_HID    = 8'h21;
  localparam logic [7:0] DT_REPORT = 8'h22;

  localparam logic [7:0] DEFAULT_COMMAND = 8'hAE;

  // Segment offsets and lengths in the descriptor table.
  localparam logic [7:0]       DEV_BASE = 8'd0;
  localparam logic [LEN_W-1:0] DEV_LEN  = 7'd18;
  localparam logic [7:0]       CFG_BASE = 8'd18;
  localparam logic [LEN_W-1:0] CFG_LEN  = 7'd84;
  localparam logic [7:0]       RPT0_BASE = 8'd102;
  localparam logic [LEN_W-1:0] RPT0_LEN  = 7'd65;
  localparam logic [7:0]       RPT1_BASE = 8'd167;
  localparam logic [LEN_W-1:0] RPT1_LEN  = 7'd39;
  localparam logic [7:0]       RPT2_BASE = 8'd206;
  localparam logic [LEN_W-1:0] RPT2_LEN  = 7'd38;
  localparam logic [7:0]       HID0_BASE = 8'd36;
  localparam logic [7:0]       HID1_BASE = 8'd61;
  localparam logic [7:0]       HID2_BASE = 8'd86;
  localparam logic [LEN_W-1:0] HID_LEN   = 7'd9;

  // Segment offsets and lengths in the string table.
  localparam logic [7:0]       STR0_BASE  = 8'd0;
  localparam logic [LEN_W-1:0] STR0_LEN   = 7'd4;
  localparam logic [7:0]       STR1_BASE  = 8'd4;
  localparam logic [LEN_W-1:0] STR1_LEN   = 7'd30;
  localparam logic [7:0]       STR2_BASE  = 8'd34;
  localparam logic [LEN_W-1:0] STR2_LEN   = 7'd44;
  localparam logic [7:0]       STR3_BASE  = 8'd78;
  localparam logic [LEN_W-1:0] STR3_LEN   = 7'd22;
  localparam logic [7:0]       STRX_BASE  = 8'd100;
  localparam logic [LEN_W-1:0] STRX_LEN   = 7'd2;

  localparam logic [LEN_W-1:0] STATUS_LEN   = 7'd2;
  localparam logic [LEN_W-1:0] PROTOCOL_LEN = 7'd1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_STALL = 2'd2
  } reply_kind_e;

  typedef enum logic [1:0] {
    SRC_DESC   = 2'd0,
    SRC_STR    = 2'd1,
    SRC_REPORT = 2'd2,
    SRC_ZERO   = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_BEAT   = 2'd2
  } state_e;

  typedef struct packed {
    logic             single;
    reply_kind_e      kind;
    src_e             src;
    logic [7:0]       base;
    logic [LEN_W-1:0] len;
    logic             set_cfg;
    logic             set_cmd;
  } job_t;

  typedef struct packed {
    logic [BEAT_W-1:0] data;
    logic [TAKE_W-1:0] bytes;
    logic              last;
    logic [LEN_W-1:0]  next_pos;
  } beat_t;

  localparam logic [7:0] DESC_ROM [0:DESC_DEPTH-1] = '{
    // device
    8'h12,8'h01,8'h00,8'h02,8'h00,8'h00,8'h00,8'h40,8'hde,8'h28,8'h05,8'h12,8'h00,8'h03,
    8'h01,8'h02,8'h03,8'h01,
    // configuration
    8'h09,8'h02,8'h54,8'h00,8'h03,8'h01,8'h00,8'h80,8'hFA,
    8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h00,8'h02,8'h00,
    8'h09,8'h21,8'h10,8'h01,8'h00,8'h01,8'h22,8'h41,8'h00,
    8'h07,8'h05,8'h81,8'h03,8'h08,8'h00,8'h04,
    8'h09,8'h04,8'h01,8'h00,8'h01,8'h03,8'h01,8'h01,8'h00,
    8'h09,8'h21,8'h10,8'h01,8'h00,8'h01,8'h22,8'h27,8'h00,
    8'h07,8'h05,8'h82,8'h03,8'h08,8'h00,8'h04,
    8'h09,8'h04,8'h02,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,
    8'h09,8'h21,8'h10,8'h01,8'h21,8'h01,8'h22,8'h26,8'h00,
    8'h07,8'h05,8'h83,8'h03,8'h40,8'h00,8'h04,
    // pointer report
    8'h05,8'h01,8'h09,8'h02,8'ha1,8'h01,8'h09,8'h01,8'ha1,8'h00,8'h05,8'h09,8'h19,8'h01,
    8'h29,8'h02,8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h02,8'h81,8'h02,8'h75,8'h06,
    8'h95,8'h01,8'h81,8'h01,8'h05,8'h01,8'h09,8'h30,8'h09,8'h31,8'h15,8'h81,8'h25,8'h7f,
    8'h75,8'h08,8'h95,8'h02,8'h81,8'h06,8'h95,8'h01,8'h09,8'h38,8'h81,8'h06,8'h05,8'h0c,
    8'h0a,8'h38,8'h02,8'h95,8'h01,8'h81,8'h06,8'hc0,8'hc0,
    // keyboard report
    8'h05,8'h01,8'h09,8'h06,8'ha1,8'h01,8'h05,8'h07,8'h19,8'he0,8'h29,8'he7,8'h15,8'h00,
    8'h25,8'h01,8'h75,8'h01,8'h95,8'h08,8'h81,8'h02,8'h81,8'h01,8'h19,8'h00,8'h29,8'h65,
    8'h15,8'h00,8'h25,8'h65,8'h75,8'h08,8'h95,8'h06,8'h81,8'h00,8'hc0,
    // vendor report
    8'h06,8'hff,8'hff,8'h09,8'h01,8'ha1,8'h01,8'h09,8'h02,8'h09,8'h03,8'h15,8'h00,8'h26,
    8'hff,8'h00,8'h75,8'h08,8'h95,8'h40,8'h81,8'h02,8'h09,8'h06,8'h09,8'h07,8'h15,8'h00,
    8'h26,8'hff,8'h00,8'h75,8'h08,8'h95,8'h40,8'hb1,8'h02,8'hc0
  };

  localparam logic [7:0] STR_ROM [0:STR_DEPTH-1] = '{
    // language list
    8'h04,8'h03,8'h09,8'h04,
    // manufacturer
    8'h1E,8'h03,
    8'h56,8'h00,8'h61,8'h00,8'h6C,8'h00,8'h76,8'h00,8'h65,8'h00,8'h20,8'h00,8'h53,8'h00,
    8'h6F,8'h00,8'h66,8'h00,8'h74,8'h00,8'h77,8'h00,8'h61,8'h00,8'h72,8'h00,8'h65,8'h00,
    // product
    8'h2C,8'h03,
    8'h53,8'h00,8'h74,8'h00,8'h65,8'h00,8'h61,8'h00,8'h6D,8'h00,8'h20,8'h00,8'h44,8'h00,
    8'h65,8'h00,8'h63,8'h00,8'h6B,8'h00,8'h20,8'h00,8'h43,8'h00,8'h6F,8'h00,8'h6E,8'h00,
    8'h74,8'h00,8'h72,8'h00,8'h6F,8'h00,8'h6C,8'h00,8'h6C,8'h00,8'h65,8'h00,8'h72,8'h00,
    // serial number
    8'h16,8'h03,
    8'h50,8'h00,8'h46,8'h00,8'h44,8'h00,8'h45,8'h00,8'h43,8'h00,8'h4B,8'h00,8'h30,8'h00,
    8'h30,8'h00,8'h30,8'h00,8'h31,8'h00,
    // empty string
    8'h02,8'h03
  };

  localparam logic [7:0] SERIAL_ASCII [0:9] = '{
    8'h50,8'h46,8'h44,8'h45,8'h43,8'h4B,8'h30,8'h30,8'h30,8'h31
  };

endpackage

`default_nettype wire

[rtl/usb_hid_ep0_request_responder_top.sv]
// Top level of the HID control endpoint responder: sequencer, state and output register.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | request_type_i .. report_first_byte_i
//  out     | output    | out_valid_o / out_ready_i| reply_kind_o .. is_configured_o
//
// A request is captured, then decoded, then its reply goes out beat by beat
// (up to eleven beats of eight bytes), each beat waiting while the output is stalled.
// The beat unit that reads the descriptor tables is reused for every beat of a reply.
// A new request is taken only after the last beat of the previous one sits in the output register.
// Output stalls hold the sequencer; reset clears the configured flag and the stored command.
`default_nettype none

module usb_hid_ep0_request_responder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] request_value_i,
  input  wire logic [15:0] request_index_i,
  input  wire logic [15:0] request_length_i,
  input  wire logic [7:0]  report_first_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       reply_kind_o,
  output logic [63:0]      beat_data_o,
  output logic [3:0]       beat_bytes_o,
  output logic             beat_last_o,
  output logic             is_configured_o
);

  uhid_pkg::state_e state_q, state_d;

  logic [7:0]  rtype_q, rcode_q, first_q;
  logic [15:0] rvalue_q, rindex_q, rlength_q;

  uhid_pkg::job_t             job_d, job_q;
  uhid_pkg::beat_t            beat;
  logic [uhid_pkg::LEN_W-1:0] pos_q;
  logic [7:0]                 command_q;
  logic                       configured_q;

  logic        accept;
  logic        load_out;
  logic        reply_last;

  logic                        out_valid_q;
  logic [1:0]                  kind_q;
  logic [uhid_pkg::BEAT_W-1:0] data_q;
  logic [uhid_pkg::TAKE_W-1:0] bytes_q;
  logic                        last_q;
  logic                        cfg_out_q;

  uhid_decode u_decode (
    .request_type_i   (rtype_q),
    .request_code_i   (rcode_q),
    .request_value_i  (rvalue_q),
    .request_index_i  (rindex_q),
    .request_length_i (rlength_q),
    .job_o            (job_d)
  );

  uhid_beat_unit u_beat (
    .src_i     (job_q.src),
    .base_i    (job_q.base),
    .len_i     (job_q.len),
    .pos_i     (pos_q),
    .command_i (command_q),
    .beat_o    (beat)
  );

  assign reply_last = job_q.single | beat.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uhid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      uhid_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (in_valid_i) state_d = uhid_pkg::ST_DECODE;
      end
      uhid_pkg::ST_DECODE: begin
        state_d = uhid_pkg::ST_BEAT;
      end
      uhid_pkg::ST_BEAT: begin
        load_out = !out_valid_q || out_ready_i;
        if (load_out && reply_last) state_d = uhid_pkg::ST_IDLE;
      end
      default: begin
        state_d = uhid_pkg::ST_IDLE;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rtype_q   <= request_type_i;
      rcode_q   <= request_code_i;
      rvalue_q  <= request_value_i;
      rindex_q  <= request_index_i;
      rlength_q <= request_length_i;
      first_q   <= report_first_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == uhid_pkg::ST_DECODE) begin
      job_q <= job_d;
      pos_q <= '0;
    end else if (load_out) begin
      pos_q <= beat.next_pos;
    end
  end

  // The flags change at decode, so every beat of the reply reports the new value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q    <= '0;
      configured_q <= 1'b0;
    end else if (state_q == uhid_pkg::ST_DECODE) begin
      if (job_d.set_cmd) command_q <= first_q;
      if (job_d.set_cfg) configured_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The configured flag is captured with the beat, since the next request may be
  // decoded while this beat still waits for the receiver.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      kind_q    <= job_q.kind;
      data_q    <= job_q.single ? '0 : beat.data;
      bytes_q   <= job_q.single ? '0 : beat.bytes;
      last_q    <= reply_last;
      cfg_out_q <= configured_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reply_kind_o    = kind_q;
  assign beat_data_o     = data_q;
  assign beat_bytes_o    = bytes_q;
  assign beat_last_o     = last_q;
  assign is_configured_o = cfg_out_q;

endmodule

`default_nettype wire

[rtl/uhid_decode.sv]
// Request decoder: turns a setup request into a reply job (source, base, length, side effects).
`default_nettype none

module uhid_decode (
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] request_value_i,
  input  wire logic [15:0] request_index_i,
  input  wire logic [15:0] request_length_i,
  output uhid_pkg::job_t   job_o
);

  logic [1:0]                 rtype;
  logic [7:0]                 dtype;
  logic [7:0]                 didx;
  logic [7:0]                 iface;
  logic [uhid_pkg::LEN_W-1:0] full_len;
  logic [uhid_pkg::LEN_W-1:0] clamped_len;
  logic                       clamp;

  assign rtype = request_type_i[6:5];
  assign dtype = request_value_i[15:8];
  assign didx  = request_value_i[7:0];
  assign iface = request_index_i[7:0];

  // The data length is the segment length, or wLength when that is shorter.
  assign clamped_len = (request_length_i < 16'(full_len)) ?
                       request_length_i[uhid_pkg::LEN_W-1:0] : full_len;

  always_comb begin
    job_o          = '0;
    job_o.single   = 1'b1;
    job_o.kind     = uhid_pkg::KIND_STALL;
    job_o.src      = uhid_pkg::SRC_ZERO;
    full_len       = '0;
    clamp          = 1'b0;

    case (rtype)
      uhid_pkg::RT_STANDARD: begin
        case (request_code_i)
          uhid_pkg::STD_GET_DESCRIPTOR: begin
            job_o.single = 1'b0;
            job_o.kind   = uhid_pkg::KIND_DATA;
            job_o.src    = uhid_pkg::SRC_DESC;
            case (dtype)
              uhid_pkg::DT_DEVICE: begin
                job_o.base = uhid_pkg::DEV_BASE;
                full_len   = uhid_pkg::DEV_LEN;
              end
              uhid_pkg::DT_CONFIG: begin
                job_o.base = uhid_pkg::CFG_BASE;
                full_len   = uhid_pkg::CFG_LEN;
                clamp      = 1'b1;
              end
              uhid_pkg::DT_STRING: begin
                job_o.src = uhid_pkg::SRC_STR;
                clamp     = 1'b1;
                case (didx)
                  8'd0: begin
                    job_o.base = uhid_pkg::STR0_BASE;
                    full_len   = uhid_pkg::STR0_LEN;
                  end
                  8'd1: begin
                    job_o.base = uhid_pkg::STR1_BASE;
                    full_len   = uhid_pkg::STR1_LEN;
                  end
                  8'd2: begin
                    job_o.base = uhid_pkg::STR2_BASE;
                    full_len   = uhid_pkg::STR2_LEN;
                  end
                  8'd3: begin
                    job_o.base = uhid_pkg::STR3_BASE;
                    full_len   = uhid_pkg::STR3_LEN;
                  end
                  default: begin
                    job_o.base = uhid_pkg::STRX_BASE;
                    full_len   = uhid_pkg::STRX_LEN;
                  end
                endcase
              end
              uhid_pkg::DT_REPORT: begin
                clamp = 1'b1;
                case (iface)
                  8'd0: begin
                    job_o.base = uhid_pkg::RPT0_BASE;
                    full_len   = uhid_pkg::RPT0_LEN;
                  end
                  8'd1: begin
                    job_o.base = uhid_pkg::RPT1_BASE;
                    full_len   = uhid_pkg::RPT1_LEN;
                  end
                  default: begin
                    job_o.base = uhid_pkg::RPT2_BASE;
                    full_len   = uhid_pkg::RPT2_LEN;
                  end
                endcase
              end
              uhid_pkg::DT_HID: begin
                full_len = uhid_pkg::HID_LEN;
                case (iface)
                  8'd0:    job_o.base = uhid_pkg::HID0_BASE;
                  8'd1:    job_o.base = uhid_pkg::HID1_BASE;
                  default: job_o.base = uhid_pkg::HID2_BASE;
                endcase
              end
              default: begin
                job_o.single = 1'b1;
                job_o.kind   = uhid_pkg::KIND_STALL;
              end
            endcase
          end
          uhid_pkg::STD_SET_CONFIG: begin
            job_o.kind    = uhid_pkg::KIND_ACK;
            job_o.set_cfg = 1'b1;
          end
          uhid_pkg::STD_SET_INTERFACE: begin
            job_o.kind = uhid_pkg::KIND_ACK;
          end
          uhid_pkg::STD_GET_STATUS: begin
            job_o.single = 1'b0;
            job_o.kind   = uhid_pkg::KIND_DATA;
            full_len     = uhid_pkg::STATUS_LEN;
          end
          default: begin
            job_o.kind = uhid_pkg::KIND_STALL;
          end
        endcase
      end
      uhid_pkg::RT_CLASS: begin
        case (request_code_i)
          uhid_pkg::HID_GET_REPORT: begin
            job_o.single = 1'b0;
            job_o.kind   = uhid_pkg::KIND_DATA;
            job_o.src    = uhid_pkg::SRC_REPORT;
            full_len     = uhid_pkg::LEN_W'(uhid_pkg::MAX_REPORT_BYTES);
            clamp        = 1'b1;
          end
          uhid_pkg::HID_SET_REPORT: begin
            job_o.kind    = uhid_pkg::KIND_ACK;
            job_o.set_cmd = (request_length_i != 16'd0);
          end
          uhid_pkg::HID_SET_IDLE, uhid_pkg::HID_SET_PROTOCOL: begin
            job_o.kind = uhid_pkg::KIND_ACK;
          end
          uhid_pkg::HID_GET_PROTOCOL: begin
            job_o.single = 1'b0;
            job_o.kind   = uhid_pkg::KIND_DATA;
            full_len     = uhid_pkg::PROTOCOL_LEN;
          end
          default: begin
            job_o.kind = uhid_pkg::KIND_STALL;
          end
        endcase
      end
      default: begin
        job_o.kind = uhid_pkg::KIND_STALL;
      end
    endcase

    job_o.len = clamp ? clamped_len : full_len;
  end

endmodule

`default_nettype wire

[rtl/uhid_beat_unit.sv]
// Beat unit: reads the next group of reply bytes from the tables, the report blob or zeros, and sizes the beat.
`default_nettype none

module uhid_beat_unit (
  input  wire uhid_pkg::src_e             src_i,
  input  wire logic [7:0]                 base_i,
  input  wire logic [uhid_pkg::LEN_W-1:0] len_i,
  input  wire logic [uhid_pkg::LEN_W-1:0] pos_i,
  input  wire logic [7:0]                 command_i,
  output uhid_pkg::beat_t                 beat_o
);

  logic [uhid_pkg::LEN_W-1:0]  remain;
  logic [uhid_pkg::TAKE_W-1:0] take;
  logic [7:0]                  cmd_eff;

  assign remain  = len_i - pos_i;
  assign take    = (remain > uhid_pkg::LEN_W'(uhid_pkg::BEAT_BYTES)) ?
                   uhid_pkg::TAKE_W'(uhid_pkg::BEAT_BYTES) : remain[uhid_pkg::TAKE_W-1:0];
  assign cmd_eff = (command_i == 8'd0) ? uhid_pkg::DEFAULT_COMMAND : command_i;

  always_comb begin
    logic [uhid_pkg::LEN_W-1:0] idx;
    logic [8:0]                 addr;
    logic [7:0]                 lane_byte;

    beat_o          = '0;
    idx             = '0;
    addr            = '0;
    lane_byte       = '0;
    beat_o.bytes    = take;
    beat_o.next_pos = pos_i + uhid_pkg::LEN_W'(take);
    beat_o.last     = (beat_o.next_pos >= len_i);

    for (int b = 0; b < uhid_pkg::BEAT_BYTES; b++) begin
      idx       = pos_i + uhid_pkg::LEN_W'(b);
      addr      = 9'(base_i) + 9'(idx);
      lane_byte = 8'd0;
      case (src_i)
        uhid_pkg::SRC_DESC: begin
          if (addr < 9'(uhid_pkg::DESC_DEPTH)) lane_byte = uhid_pkg::DESC_ROM[addr[7:0]];
        end
        uhid_pkg::SRC_STR: begin
          if (addr < 9'(uhid_pkg::STR_DEPTH)) lane_byte = uhid_pkg::STR_ROM[addr[6:0]];
        end
        uhid_pkg::SRC_REPORT: begin
          // Report blob: command, length, one, then the serial number in ASCII.
          if (idx == 7'd0)      lane_byte = cmd_eff;
          else if (idx == 7'd1) lane_byte = 8'd10;
          else if (idx == 7'd2) lane_byte = 8'd1;
          else if (idx < 7'd13) lane_byte = uhid_pkg::SERIAL_ASCII[4'(idx - 7'd3)];
        end
        default: lane_byte = 8'd0;
      endcase
      if (uhid_pkg::TAKE_W'(b) < take) beat_o.data[8*b +: 8] = lane_byte;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the HID control endpoint responder: directed table, then random requests.
`default_nettype none

module tb;
  import uhid_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 456;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned TAIL_CYCLES    = 20;

  // bmRequestType values: direction bit set for device-to-host requests.
  localparam logic [7:0] REQ_STD_IN    = 8'h80;
  localparam logic [7:0] REQ_STD_OUT   = 8'h00;
  localparam logic [7:0] REQ_CLASS_IN  = 8'hA1;
  localparam logic [7:0] REQ_CLASS_OUT = 8'h21;
  localparam logic [7:0] REQ_VENDOR    = 8'hC0;
  localparam logic [7:0] REQ_RESERVED  = 8'hFF;

  localparam logic [7:0] DEVICE_DESC [18] = '{
    8'h12,8'h01,8'h00,8'h02,8'h00,8'h00,8'h00,8'h40,8'hde,8'h28,8'h05,8'h12,8'h00,8'h03,
    8'h01,8'h02,8'h03,8'h01
  };

  localparam logic [7:0] CONFIG_DESC [84] = '{
    8'h09,8'h02,8'h54,8'h00,8'h03,8'h01,8'h00,8'h80,8'hFA,
    8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h00,8'h02,8'h00,
    8'h09,8'h21,8'h10,8'h01,8'h00,8'h01,8'h22,8'h41,8'h00,
    8'h07,8'h05,8'h81,8'h03,8'h08,8'h00,8'h04,
    8'h09,8'h04,8'h01,8'h00,8'h01,8'h03,8'h01,8'h01,8'h00,
    8'h09,8'h21,8'h10,8'h01,8'h00,8'h01,8'h22,8'h27,8'h00,
    8'h07,8'h05,8'h82,8'h03,8'h08,8'h00,8'h04,
    8'h09,8'h04,8'h02,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,
    8'h09,8'h21,8'h10,8'h01,8'h21,8'h01,8'h22,8'h26,8'h00,
    8'h07,8'h05,8'h83,8'h03,8'h40,8'h00,8'h04
  };

  localparam logic [7:0] POINTER_REPORT [65] = '{
    8'h05,8'h01,8'h09,8'h02,8'ha1,8'h01,8'h09,8'h01,8'ha1,8'h00,8'h05,8'h09,8'h19,8'h01,
    8'h29,8'h02,8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h02,8'h81,8'h02,8'h75,8'h06,
    8'h95,8'h01,8'h81,8'h01,8'h05,8'h01,8'h09,8'h30,8'h09,8'h31,8'h15,8'h81,8'h25,8'h7f,
    8'h75,8'h08,8'h95,8'h02,8'h81,8'h06,8'h95,8'h01,8'h09,8'h38,8'h81,8'h06,8'h05,8'h0c,
    8'h0a,8'h38,8'h02,8'h95,8'h01,8'h81,8'h06,8'hc0,8'hc0
  };

  localparam logic [7:0] KEYBOARD_REPORT [39] = '{
    8'h05,8'h01,8'h09,8'h06,8'ha1,8'h01,8'h05,8'h07,8'h19,8'he0,8'h29,8'he7,8'h15,8'h00,
    8'h25,8'h01,8'h75,8'h01,8'h95,8'h08,8'h81,8'h02,8'h81,8'h01,8'h19,8'h00,8'h29,8'h65,
    8'h15,8'h00,8'h25,8'h65,8'h75,8'h08,8'h95,8'h06,8'h81,8'h00,8'hc0
  };

  localparam logic [7:0] VENDOR_REPORT [38] = '{
    8'h06,8'hff,8'hff,8'h09,8'h01,8'ha1,8'h01,8'h09,8'h02,8'h09,8'h03,8'h15,8'h00,8'h26,
    8'hff,8'h00,8'h75,8'h08,8'h95,8'h40,8'h81,8'h02,8'h09,8'h06,8'h09,8'h07,8'h15,8'h00,
    8'h26,8'hff,8'h00,8'h75,8'h08,8'h95,8'h40,8'hb1,8'h02,8'hc0
  };

  localparam logic [7:0] MAKER_TEXT [14] = '{
    8'h56,8'h61,8'h6C,8'h76,8'h65,8'h20,8'h53,8'h6F,8'h66,8'h74,8'h77,8'h61,8'h72,8'h65
  };

  localparam logic [7:0] PRODUCT_TEXT [21] = '{
    8'h53,8'h74,8'h65,8'h61,8'h6D,8'h20,8'h44,8'h65,8'h63,8'h6B,8'h20,8'h43,8'h6F,8'h6E,
    8'h74,8'h72,8'h6F,8'h6C,8'h6C,8'h65,8'h72
  };

  localparam logic [7:0] SERIAL_TEXT [10] = '{
    8'h50,8'h46,8'h44,8'h45,8'h43,8'h4B,8'h30,8'h30,8'h30,8'h31
  };

  typedef struct packed {
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic [7:0]  first;
  } request_t;

  typedef struct packed {
    reply_kind_e kind;
    logic [63:0] data;
    logic [3:0]  bytes;
    logic        last;
    logic        configured;
  } reply_t;

  typedef struct packed {
    request_t req;
    logic     pinned;
    reply_t   reply;
  } directed_row_t;

  localparam reply_t STALL_UNCFG = '{KIND_STALL, 64'h0, 4'd0, 1'b1, 1'b0};
  localparam reply_t STALL_CFG   = '{KIND_STALL, 64'h0, 4'd0, 1'b1, 1'b1};
  localparam reply_t ACK_UNCFG   = '{KIND_ACK, 64'h0, 4'd0, 1'b1, 1'b0};
  localparam reply_t ACK_CFG     = '{KIND_ACK, 64'h0, 4'd0, 1'b1, 1'b1};

  // Rows with pinned set carry their reply spelled out; the rest go through the predictor.
  localparam directed_row_t DIRECTED [26] = '{
    '{'{REQ_STD_IN, STD_GET_STATUS, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1,
      '{KIND_DATA, 64'h0, 4'd2, 1'b1, 1'b0}},
    '{'{REQ_CLASS_IN, HID_GET_PROTOCOL, 16'h0000, 16'h0000, 16'hFFFF, 8'h00}, 1'b1,
      '{KIND_DATA, 64'h0, 4'd1, 1'b1, 1'b0}},
    '{'{REQ_CLASS_IN, HID_GET_REPORT, 16'h0000, 16'h0000, 16'h0001, 8'h00}, 1'b1,
      '{KIND_DATA, 64'hAE, 4'd1, 1'b1, 1'b0}},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000, 16'h0000, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0000, 16'hFFFF, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0000, 16'h0000, 8'h00},
      1'b1, '{KIND_DATA, 64'h0, 4'd0, 1'b1, 1'b0}},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, 8'h00}, 16'h0409, 16'hFFFF, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, 8'h01}, 16'h0409, 16'hFFFF, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, 8'h02}, 16'h0409, 16'd43, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, 8'h03}, 16'h0409, 16'hFFFF, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, 8'hFF}, 16'h0409, 16'hFFFF, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, 16'h0000, 16'hFFFF, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, 16'hFFFF, 16'd7, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, {DT_HID, 8'h00}, 16'h0000, 16'h0000, 8'h00},
      1'b0, '0},
    '{'{REQ_STD_IN, STD_GET_DESCRIPTOR, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00}, 1'b1,
      STALL_UNCFG},
    '{'{REQ_STD_OUT, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, STALL_UNCFG},
    '{'{REQ_VENDOR, HID_GET_REPORT, 16'h0000, 16'h0000, 16'h0040, 8'h00}, 1'b1,
      STALL_UNCFG},
    '{'{REQ_RESERVED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, STALL_UNCFG},
    '{'{REQ_CLASS_OUT, HID_SET_REPORT, 16'h0000, 16'h0000, 16'h0000, 8'h55}, 1'b1,
      ACK_UNCFG},
    '{'{REQ_CLASS_OUT, HID_SET_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
      ACK_UNCFG},
    '{'{REQ_CLASS_IN, HID_GET_REPORT, 16'h0000, 16'h0000, 16'hFFFF, 8'h00}, 1'b0, '0},
    '{'{REQ_STD_OUT, STD_SET_CONFIG, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, ACK_CFG},
    '{'{REQ_STD_OUT, STD_SET_INTERFACE, 16'h0000, 16'h0001, 16'h0000, 8'h00}, 1'b1,
      ACK_CFG},
    '{'{REQ_CLASS_OUT, HID_SET_IDLE, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, ACK_CFG},
    '{'{REQ_CLASS_OUT, HID_SET_PROTOCOL, 16'h0001, 16'h0001, 16'h0000, 8'h00}, 1'b1,
      ACK_CFG},
    '{'{REQ_CLASS_OUT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, STALL_CFG}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  request_type_i = 8'h00;
  logic [7:0]  request_code_i = 8'h00;
  logic [15:0] request_value_i = 16'h0000;
  logic [15:0] request_index_i = 16'h0000;
  logic [15:0] request_length_i = 16'h0000;
  logic [7:0]  report_first_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  reply_kind_o;
  logic [63:0] beat_data_o;
  logic [3:0]  beat_bytes_o;
  logic        beat_last_o;
  logic        is_configured_o;

  // Predicted device state.
  logic [7:0]  stored_command = 8'h00;
  logic        configured = 1'b0;

  reply_t      pending_beats [$];
  int unsigned errors = 0;
  bit          no_idle = 1'b0;
  bit          rx_hold_pending = 1'b0;

  usb_hid_ep0_request_responder_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .request_type_i     (request_type_i),
    .request_code_i     (request_code_i),
    .request_value_i    (request_value_i),
    .request_index_i    (request_index_i),
    .request_length_i   (request_length_i),
    .report_first_byte_i(report_first_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .reply_kind_o       (reply_kind_o),
    .beat_data_o        (beat_data_o),
    .beat_bytes_o       (beat_bytes_o),
    .beat_last_o        (beat_last_o),
    .is_configured_o    (is_configured_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clip(input int unsigned n, input int unsigned limit);
    return (n > limit) ? limit : n;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // Works out the reply beats of one request and updates the predicted state.
  function automatic void predict_reply(input request_t r);
    logic [7:0]  payload [96];
    int unsigned total;
    int unsigned text_len;
    int unsigned hid_base;
    int unsigned pos;
    int unsigned take;
    bit          is_data;
    reply_kind_e single_kind;
    logic [7:0]  ch;
    reply_t      beat;
    foreach (payload[i]) payload[i] = 8'h00;
    is_data = 1'b0;
    single_kind = KIND_STALL;
    total = 0;
    if (r.rtype[6:5] == RT_STANDARD) begin
      case (r.code)
        STD_GET_DESCRIPTOR: begin
          is_data = 1'b1;
          case (r.value[15:8])
            DT_DEVICE: begin
              for (int i = 0; i < 18; i++) payload[i] = DEVICE_DESC[i];
              total = 18;
            end
            DT_CONFIG: begin
              for (int i = 0; i < 84; i++) payload[i] = CONFIG_DESC[i];
              total = clip(84, r.length);
            end
            DT_STRING: begin
              if (r.value[7:0] == 8'd0) begin
                payload[0] = 8'h04;
                payload[1] = DT_STRING;
                payload[2] = 8'h09;
                payload[3] = 8'h04;
                total = clip(4, r.length);
              end else begin
                case (r.value[7:0])
                  8'd1: text_len = 14;
                  8'd2: text_len = 21;
                  8'd3: text_len = 10;
                  default: text_len = 0;
                endcase
                payload[0] = 8'(2 + 2 * text_len);
                payload[1] = DT_STRING;
                // UTF-16LE: the high byte of every character stays zero.
                for (int i = 0; i < text_len; i++) begin
                  case (r.value[7:0])
                    8'd1: ch = MAKER_TEXT[i];
                    8'd2: ch = PRODUCT_TEXT[i];
                    default: ch = SERIAL_TEXT[i];
                  endcase
                  payload[2 + 2 * i] = ch;
                end
                total = clip(2 + 2 * text_len, r.length);
              end
            end
            DT_REPORT: begin
              case (r.index[7:0])
                8'd0: begin
                  for (int i = 0; i < 65; i++) payload[i] = POINTER_REPORT[i];
                  total = clip(65, r.length);
                end
                8'd1: begin
                  for (int i = 0; i < 39; i++) payload[i] = KEYBOARD_REPORT[i];
                  total = clip(39, r.length);
                end
                default: begin
                  for (int i = 0; i < 38; i++) payload[i] = VENDOR_REPORT[i];
                  total = clip(38, r.length);
                end
              endcase
            end
            DT_HID: begin
              hid_base = (r.index[7:0] == 8'd0) ? 18 : (r.index[7:0] == 8'd1) ? 43 : 68;
              for (int i = 0; i < 9; i++) payload[i] = CONFIG_DESC[hid_base + i];
              total = 9;
            end
            default: is_data = 1'b0;
          endcase
        end
        STD_SET_CONFIG: begin
          configured = 1'b1;
          single_kind = KIND_ACK;
        end
        STD_SET_INTERFACE: single_kind = KIND_ACK;
        STD_GET_STATUS: begin
          is_data = 1'b1;
          total = 2;
        end
        default: ;
      endcase
    end else if (r.rtype[6:5] == RT_CLASS) begin
      case (r.code)
        HID_GET_REPORT: begin
          is_data = 1'b1;
          payload[0] = (stored_command != 8'h00) ? stored_command : DEFAULT_COMMAND;
          payload[1] = 8'd10;
          payload[2] = 8'd1;
          for (int i = 0; i < 10; i++) payload[3 + i] = SERIAL_TEXT[i];
          total = clip(r.length, MAX_REPORT_BYTES);
        end
        HID_SET_REPORT: begin
          if (r.length != 16'h0000) stored_command = r.first;
          single_kind = KIND_ACK;
        end
        HID_SET_IDLE, HID_SET_PROTOCOL: single_kind = KIND_ACK;
        HID_GET_PROTOCOL: begin
          is_data = 1'b1;
          total = 1;
        end
        default: ;
      endcase
    end

    if (!is_data) begin
      pending_beats.push_back('{single_kind, 64'h0, 4'd0, 1'b1, configured});
    end else begin
      // A zero-length reply still produces one empty beat.
      pos = 0;
      do begin
        take = clip(total - pos, BEAT_BYTES);
        beat.kind = KIND_DATA;
        beat.data = 64'h0;
        for (int i = 0; i < take; i++) beat.data[8 * i +: 8] = payload[pos + i];
        pos += take;
        beat.bytes = 4'(take);
        beat.last = (pos >= total);
        beat.configured = configured;
        pending_beats.push_back(beat);
      end while (pos < total);
    end
  endfunction

  // Mostly well-formed requests with random content, plus some vendor and raw noise.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.rtype = 8'($urandom);
    r.code = 8'($urandom);
    r.value = 16'($urandom);
    r.index = 16'($urandom);
    r.length = 16'($urandom);
    r.first = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.rtype[6:5] = RT_STANDARD;
      r.code = STD_GET_DESCRIPTOR;
      case ($urandom_range(0, 5))
        0: r.value[15:8] = DT_DEVICE;
        1: r.value[15:8] = DT_CONFIG;
        2: r.value[15:8] = DT_STRING;
        3: r.value[15:8] = DT_REPORT;
        4: r.value[15:8] = DT_HID;
        default: ;
      endcase
      if ($urandom_range(0, 3) != 0) r.value[7:0] = 8'($urandom_range(0, 4));
      if ($urandom_range(0, 3) != 0) r.index[7:0] = 8'($urandom_range(0, 3));
    end else if (pick < 60) begin
      r.rtype[6:5] = RT_STANDARD;
      case ($urandom_range(0, 3))
        0: r.code = STD_GET_STATUS;
        1: r.code = STD_SET_CONFIG;
        2: r.code = STD_SET_INTERFACE;
        default: ;
      endcase
    end else if (pick < 90) begin
      r.rtype[6:5] = RT_CLASS;
      case ($urandom_range(0, 6))
        0, 1: r.code = HID_GET_REPORT;
        2: r.code = HID_SET_REPORT;
        3: r.code = HID_SET_IDLE;
        4: r.code = HID_SET_PROTOCOL;
        5: r.code = HID_GET_PROTOCOL;
        default: ;
      endcase
    end else if (pick < 95) begin
      r.rtype[6:5] = 2'($urandom_range(2, 3));
    end
    case ($urandom_range(0, 4))
      0: ;
      1: r.length = 16'h0000;
      2: r.length = 16'hFFFF;
      default: r.length = 16'($urandom_range(1, 100));
    endcase
    return r;
  endfunction

  task automatic send_request(input request_t r, input logic pinned, input reply_t reply);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    request_type_i <= r.rtype;
    request_code_i <= r.code;
    request_value_i <= r.value;
    request_index_i <= r.index;
    request_length_i <= r.length;
    report_first_byte_i <= r.first;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reply(r);
    if (pinned) pending_beats[pending_beats.size() - 1] = reply;
  endtask

  task automatic await_all_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k < 26; k++) begin
      send_request(DIRECTED[k].req, DIRECTED[k].pinned, DIRECTED[k].reply);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // The receiver holds off long enough for the block to back up into the request side.
      if (n == 100) rx_hold_pending = 1'b1;
      if (n == 220) await_all_replies();
      no_idle = (n >= 300 && n < 360);
      send_request(random_request(), 1'b0, '0);
    end
    await_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait();
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        stall = RX_HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    reply_t      want;
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_beats.size() == 0) begin
          $error("reply beat with no request outstanding: kind %0d, data %0h",
                 reply_kind_o, beat_data_o);
          errors++;
        end else begin
          want = pending_beats.pop_front();
          check_field("reply_kind", 64'(want.kind), 64'(reply_kind_o));
          check_field("beat_data", want.data, beat_data_o);
          check_field("beat_bytes", 64'(want.bytes), 64'(beat_bytes_o));
          check_field("beat_last", 64'(want.last), 64'(beat_last_o));
          check_field("is_configured", 64'(want.configured), 64'(is_configured_o));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

[files.f]
rtl/uhid_pkg.sv
rtl/uhid_decode.sv
rtl/uhid_beat_unit.sv
rtl/usb_hid_ep0_request_responder_top.sv
tb/tb.sv
